// ===== hdl/msbs_pkg.sv =====
`default_nettype none
package msbs_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned TRACK_W   = 7;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned VERSION_W = 2;
   localparam int unsigned CONF_W    = 7;
   localparam int unsigned HIST_DEPTH = 4;

   localparam logic [TRACK_W-1:0] EXT_THRESHOLD_RESET = 7'd35;

   // v1 signature, oldest byte first
   localparam logic [BYTE_W-1:0] V1_B4 = 8'h52;
   localparam logic [BYTE_W-1:0] V1_B3 = 8'h41;
   localparam logic [BYTE_W-1:0] V1_B2 = 8'h50;
   localparam logic [BYTE_W-1:0] V1_B1 = 8'h49;
   localparam logic [BYTE_W-1:0] V1_B0 = 8'h44;

   // v2 signature
   localparam logic [BYTE_W-1:0] V2_B3 = 8'hA9;
   localparam logic [BYTE_W-1:0] V2_B2 = 8'h00;
   localparam logic [BYTE_W-1:0] V2_B1 = 8'h85;
   localparam logic [BYTE_W-1:0] V2_B0 = 8'h02;

   // alternate signature
   localparam logic [BYTE_W-1:0] ALT_B4 = 8'hA9;
   localparam logic [BYTE_W-1:0] ALT_B3 = 8'h0B;
   localparam logic [BYTE_W-1:0] ALT_B2 = 8'h8D;
   localparam logic [BYTE_W-1:0] ALT_B1 = 8'h00;
   localparam logic [BYTE_W-1:0] ALT_B0 = 8'h18;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE      = 2'd0,
      KIND_PRIMARY   = 2'd1,
      KIND_ALTERNATE = 2'd2,
      KIND_EXTENDED  = 2'd3
   } kind_type;

   localparam logic [VERSION_W-1:0] VERSION_NONE = 2'd0;
   localparam logic [VERSION_W-1:0] VERSION_ONE  = 2'd1;
   localparam logic [VERSION_W-1:0] VERSION_TWO  = 2'd2;

   localparam logic [CONF_W-1:0] CONF_V1       = 7'd95;
   localparam logic [CONF_W-1:0] CONF_V2       = 7'd90;
   localparam logic [CONF_W-1:0] CONF_ALTERNATE = 7'd85;
   localparam logic [CONF_W-1:0] CONF_EXTENDED = 7'd70;
   localparam logic [CONF_W-1:0] CONF_NONE     = 7'd0;

   typedef struct packed {
      logic first;
      logic second;
      logic alternate;
   } hits_type;

   typedef struct packed {
      logic                 detected;
      kind_type             kind;
      logic [VERSION_W-1:0] version;
      logic [TRACK_W-1:0]   sig_track;
      logic [TRACK_W-1:0]   ext_track;
      logic [CONF_W-1:0]    confidence_pct;
   } result_type;

endpackage
`default_nettype wire

// ===== hdl/multi_signature_byte_scanner.sv =====
// Scans the bytes of one track, one byte per clock, for three fixed signatures
// (v1 52 41 50 49 44, v2 A9 00 85 02, alternate A9 0B 8D 00 18) that lie wholly
// inside the track. The last byte of a track yields one verdict in priority
// order v1, v2, alternate, then extended track (track number above the
// threshold register, reset 35); a track with none of these yields an all-zero
// verdict, and every other byte yields none. A byte is taken every clock while
// the verdict register is empty or being drained in the same cycle; the
// verdict is registered and shows in the cycle after its last byte. The byte
// history is a row of four cells that shift per transfer, clear at track end.
`default_nettype none
module multi_signature_byte_scanner (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [msbs_pkg::BYTE_W-1:0]         req_data_byte,
   input  wire logic                                req_last_byte,
   input  wire logic [msbs_pkg::TRACK_W-1:0]        req_track_number,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_detected,
   output logic      [msbs_pkg::KIND_W-1:0]         rsp_kind,
   output logic      [msbs_pkg::VERSION_W-1:0]      rsp_version,
   output logic      [msbs_pkg::TRACK_W-1:0]        rsp_sig_track,
   output logic      [msbs_pkg::TRACK_W-1:0]        rsp_ext_track,
   output logic      [msbs_pkg::CONF_W-1:0]         rsp_confidence_pct,
   input  wire logic                                csr_write_enable,
   input  wire logic [msbs_pkg::TRACK_W-1:0]        csr_write_data
);

   localparam int unsigned DEPTH = msbs_pkg::HIST_DEPTH;

   logic                          transfer;
   logic                          rsp_valid_int;
   logic [msbs_pkg::BYTE_W-1:0]   cell_byte  [DEPTH];
   logic                          cell_valid [DEPTH];
   logic [msbs_pkg::TRACK_W-1:0]  threshold_ff;
   logic [msbs_pkg::TRACK_W-1:0]  threshold_in;
   msbs_pkg::hits_type            found_ff;
   msbs_pkg::hits_type            found_in;
   msbs_pkg::hits_type            match;
   msbs_pkg::hits_type            hits;
   msbs_pkg::result_type          result;

   assign req_ready = !rsp_valid_int || rsp_ready;
   assign transfer  = req_valid && req_ready;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         if (i == 0) begin : g_head
            msbs_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .advance   (transfer),
               .clear     (req_last_byte),
               .in_byte   (req_data_byte),
               .in_valid  (1'b1),
               .out_byte  (cell_byte[i]),
               .out_valid (cell_valid[i])
            );
         end else begin : g_body
            msbs_cell u_cell (
               .clock     (clock),
               .reset     (reset),
               .advance   (transfer),
               .clear     (req_last_byte),
               .in_byte   (cell_byte[i-1]),
               .in_valid  (cell_valid[i-1]),
               .out_byte  (cell_byte[i]),
               .out_valid (cell_valid[i])
            );
         end
      end
   endgenerate

   always_comb begin
      match.first = cell_valid[3]
         && cell_byte[3] == msbs_pkg::V1_B4 && cell_byte[2] == msbs_pkg::V1_B3
         && cell_byte[1] == msbs_pkg::V1_B2 && cell_byte[0] == msbs_pkg::V1_B1
         && req_data_byte == msbs_pkg::V1_B0;
      match.second = cell_valid[2]
         && cell_byte[2] == msbs_pkg::V2_B3 && cell_byte[1] == msbs_pkg::V2_B2
         && cell_byte[0] == msbs_pkg::V2_B1 && req_data_byte == msbs_pkg::V2_B0;
      match.alternate = cell_valid[3]
         && cell_byte[3] == msbs_pkg::ALT_B4 && cell_byte[2] == msbs_pkg::ALT_B3
         && cell_byte[1] == msbs_pkg::ALT_B2 && cell_byte[0] == msbs_pkg::ALT_B1
         && req_data_byte == msbs_pkg::ALT_B0;
      hits = found_ff | match;
   end

   always_comb begin
      found_in = found_ff;
      if (transfer) begin
         if (req_last_byte) begin
            found_in = '0;
         end else begin
            found_in = hits;
         end
      end
   end

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_write_enable) begin
         threshold_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= '0;
         threshold_ff <= msbs_pkg::EXT_THRESHOLD_RESET;
      end else begin
         found_ff     <= found_in;
         threshold_ff <= threshold_in;
      end
   end

   msbs_verdict u_verdict (
      .clock     (clock),
      .reset     (reset),
      .load      (transfer && req_last_byte),
      .hits      (hits),
      .track     (req_track_number),
      .threshold (threshold_ff),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid_int),
      .result    (result)
   );

   assign rsp_valid          = rsp_valid_int;
   assign rsp_detected       = result.detected;
   assign rsp_kind           = result.kind;
   assign rsp_version        = result.version;
   assign rsp_sig_track      = result.sig_track;
   assign rsp_ext_track      = result.ext_track;
   assign rsp_confidence_pct = result.confidence_pct;

endmodule
`default_nettype wire

// ===== hdl/msbs_cell.sv =====
`default_nettype none
module msbs_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          clear,
   input  wire logic [msbs_pkg::BYTE_W-1:0]   in_byte,
   input  wire logic                          in_valid,
   output logic      [msbs_pkg::BYTE_W-1:0]   out_byte,
   output logic                               out_valid
);

   logic [msbs_pkg::BYTE_W-1:0] byte_ff;
   logic [msbs_pkg::BYTE_W-1:0] byte_in;
   logic                        valid_ff;
   logic                        valid_in;

   always_comb begin
      byte_in  = byte_ff;
      valid_in = valid_ff;
      if (advance) begin
         if (clear) begin
            byte_in  = '0;
            valid_in = 1'b0;
         end else begin
            byte_in  = in_byte;
            valid_in = in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign out_byte  = byte_ff;
   assign out_valid = valid_ff;

endmodule
`default_nettype wire

// ===== hdl/msbs_verdict.sv =====
`default_nettype none
module msbs_verdict (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           load,
   input  wire msbs_pkg::hits_type             hits,
   input  wire logic [msbs_pkg::TRACK_W-1:0]   track,
   input  wire logic [msbs_pkg::TRACK_W-1:0]   threshold,
   input  wire logic                           out_ready,
   output logic                                out_valid,
   output msbs_pkg::result_type                result
);

   msbs_pkg::result_type result_ff;
   msbs_pkg::result_type result_in;
   logic                 valid_ff;
   logic                 valid_in;

   always_comb begin
      result_in.detected       = 1'b1;
      result_in.kind           = msbs_pkg::KIND_NONE;
      result_in.version        = msbs_pkg::VERSION_NONE;
      result_in.sig_track      = '0;
      result_in.ext_track      = '0;
      result_in.confidence_pct = msbs_pkg::CONF_NONE;
      if (hits.first) begin
         result_in.kind           = msbs_pkg::KIND_PRIMARY;
         result_in.version        = msbs_pkg::VERSION_ONE;
         result_in.sig_track      = track;
         result_in.confidence_pct = msbs_pkg::CONF_V1;
      end else if (hits.second) begin
         result_in.kind           = msbs_pkg::KIND_PRIMARY;
         result_in.version        = msbs_pkg::VERSION_TWO;
         result_in.sig_track      = track;
         result_in.confidence_pct = msbs_pkg::CONF_V2;
      end else if (hits.alternate) begin
         result_in.kind           = msbs_pkg::KIND_ALTERNATE;
         result_in.sig_track      = track;
         result_in.confidence_pct = msbs_pkg::CONF_ALTERNATE;
      end else if (track > threshold) begin
         result_in.kind           = msbs_pkg::KIND_EXTENDED;
         result_in.ext_track      = track;
         result_in.confidence_pct = msbs_pkg::CONF_EXTENDED;
      end else begin
         result_in.detected = 1'b0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign out_valid = valid_ff;
   assign result    = result_ff;

endmodule
`default_nettype wire

// ===== verif/scan_verdict_checker.sv =====
`timescale 1ns / 1ps
module scan_verdict_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic [msbs_pkg::BYTE_W-1:0]    req_data_byte,
   input  wire logic                           req_last_byte,
   input  wire logic [msbs_pkg::TRACK_W-1:0]   req_track_number,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic                           rsp_detected,
   input  wire logic [msbs_pkg::KIND_W-1:0]    rsp_kind,
   input  wire logic [msbs_pkg::VERSION_W-1:0] rsp_version,
   input  wire logic [msbs_pkg::TRACK_W-1:0]   rsp_sig_track,
   input  wire logic [msbs_pkg::TRACK_W-1:0]   rsp_ext_track,
   input  wire logic [msbs_pkg::CONF_W-1:0]    rsp_confidence_pct,
   input  wire logic                           csr_write_enable,
   input  wire logic [msbs_pkg::TRACK_W-1:0]   csr_write_data,
   output int                                  fail_count,
   output int                                  verdicts_owed
);

   localparam logic [39:0] V1_WORD  = 40'h52_41_50_49_44;
   localparam logic [31:0] V2_WORD  = 32'hA9_00_85_02;
   localparam logic [39:0] ALT_WORD = 40'hA9_0B_8D_00_18;

   logic [msbs_pkg::TRACK_W-1:0] ext_limit;
   logic [31:0]                  recent;
   logic [2:0]                   seen;
   msbs_pkg::hits_type           hits;
   msbs_pkg::result_type         verdict_q[$];

   initial begin
      fail_count = 0;
      verdicts_owed = 0;
   end

   function automatic msbs_pkg::result_type judge_track(
         input msbs_pkg::hits_type h,
         input logic [msbs_pkg::TRACK_W-1:0] trk,
         input logic [msbs_pkg::TRACK_W-1:0] lim);
      msbs_pkg::result_type r;
      r = '0;
      r.kind = msbs_pkg::KIND_NONE;
      r.version = msbs_pkg::VERSION_NONE;
      r.confidence_pct = msbs_pkg::CONF_NONE;
      if (h.first) begin
         r.detected = 1'b1;
         r.kind = msbs_pkg::KIND_PRIMARY;
         r.version = msbs_pkg::VERSION_ONE;
         r.sig_track = trk;
         r.confidence_pct = msbs_pkg::CONF_V1;
      end else if (h.second) begin
         r.detected = 1'b1;
         r.kind = msbs_pkg::KIND_PRIMARY;
         r.version = msbs_pkg::VERSION_TWO;
         r.sig_track = trk;
         r.confidence_pct = msbs_pkg::CONF_V2;
      end else if (h.alternate) begin
         r.detected = 1'b1;
         r.kind = msbs_pkg::KIND_ALTERNATE;
         r.sig_track = trk;
         r.confidence_pct = msbs_pkg::CONF_ALTERNATE;
      end else if (trk > lim) begin
         r.detected = 1'b1;
         r.kind = msbs_pkg::KIND_EXTENDED;
         r.ext_track = trk;
         r.confidence_pct = msbs_pkg::CONF_EXTENDED;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      logic [39:0]          window;
      msbs_pkg::result_type want;
      int                   errs;
      errs = 0;
      if (reset) begin
         ext_limit = msbs_pkg::EXT_THRESHOLD_RESET;
         recent = '0;
         seen = '0;
         hits = '0;
         verdict_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $error("verdict transfer with nothing expected");
               errs++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_detected !== want.detected) begin
                  $error("detected expected %0d actual %0d", want.detected, rsp_detected);
                  errs++;
               end
               if (rsp_kind !== want.kind) begin
                  $error("kind expected %0d actual %0d", want.kind, rsp_kind);
                  errs++;
               end
               if (rsp_version !== want.version) begin
                  $error("version expected %0d actual %0d", want.version, rsp_version);
                  errs++;
               end
               if (rsp_sig_track !== want.sig_track) begin
                  $error("sig_track expected %0d actual %0d", want.sig_track, rsp_sig_track);
                  errs++;
               end
               if (rsp_ext_track !== want.ext_track) begin
                  $error("ext_track expected %0d actual %0d", want.ext_track, rsp_ext_track);
                  errs++;
               end
               if (rsp_confidence_pct !== want.confidence_pct) begin
                  $error("confidence_pct expected %0d actual %0d",
                         want.confidence_pct, rsp_confidence_pct);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) begin
            window = {recent, req_data_byte};
            if (seen >= 3'd4 && window == V1_WORD) hits.first = 1'b1;
            if (seen >= 3'd3 && window[31:0] == V2_WORD) hits.second = 1'b1;
            if (seen >= 3'd4 && window == ALT_WORD) hits.alternate = 1'b1;
            recent = window[31:0];
            if (seen < 3'd4) seen = seen + 3'd1;
            if (req_last_byte) begin
               verdict_q.push_back(judge_track(hits, req_track_number, ext_limit));
               recent = '0;
               seen = '0;
               hits = '0;
            end
         end
         if (csr_write_enable) ext_limit = csr_write_data;
      end
      fail_count <= fail_count + errs;
      verdicts_owed <= verdict_q.size();
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

   localparam int CYCLE_LIMIT = 600000;

   typedef enum int {SIG_V1, SIG_V2, SIG_ALT} sig_pick_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [msbs_pkg::BYTE_W-1:0]    req_data_byte = '0;
   logic                           req_last_byte = 1'b0;
   logic [msbs_pkg::TRACK_W-1:0]   req_track_number = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_detected;
   logic [msbs_pkg::KIND_W-1:0]    rsp_kind;
   logic [msbs_pkg::VERSION_W-1:0] rsp_version;
   logic [msbs_pkg::TRACK_W-1:0]   rsp_sig_track;
   logic [msbs_pkg::TRACK_W-1:0]   rsp_ext_track;
   logic [msbs_pkg::CONF_W-1:0]    rsp_confidence_pct;
   logic                           csr_write_enable = 1'b0;
   logic [msbs_pkg::TRACK_W-1:0]   csr_write_data = '0;

   int fail_count;
   int verdicts_owed;
   int cycle_count = 0;
   int bytes_sent = 0;
   int stall_requests = 0;
   int stall_served = 0;
   int tx_streak = 0;
   int rx_streak = 0;
   bit rush = 1'b0;
   logic [msbs_pkg::TRACK_W-1:0] ext_setting = msbs_pkg::EXT_THRESHOLD_RESET;

   always #5 clock = ~clock;

   multi_signature_byte_scanner dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_track_number   (req_track_number),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_detected       (rsp_detected),
      .rsp_kind           (rsp_kind),
      .rsp_version        (rsp_version),
      .rsp_sig_track      (rsp_sig_track),
      .rsp_ext_track      (rsp_ext_track),
      .rsp_confidence_pct (rsp_confidence_pct),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   scan_verdict_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_track_number   (req_track_number),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_detected       (rsp_detected),
      .rsp_kind           (rsp_kind),
      .rsp_version        (rsp_version),
      .rsp_sig_track      (rsp_sig_track),
      .rsp_ext_track      (rsp_ext_track),
      .rsp_confidence_pct (rsp_confidence_pct),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .fail_count         (fail_count),
      .verdicts_owed      (verdicts_owed)
   );

   function automatic int pause_cycles(inout int streak);
      if (streak > 0) begin
         streak--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         streak = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic logic [msbs_pkg::BYTE_W-1:0] sig_byte(input sig_pick_type s,
                                                            input int k);
      logic [39:0] w;
      case (s)
         SIG_V1:  w = {msbs_pkg::V1_B4, msbs_pkg::V1_B3, msbs_pkg::V1_B2,
                       msbs_pkg::V1_B1, msbs_pkg::V1_B0};
         SIG_V2:  w = {msbs_pkg::V2_B3, msbs_pkg::V2_B2, msbs_pkg::V2_B1,
                       msbs_pkg::V2_B0, 8'h00};
         default: w = {msbs_pkg::ALT_B4, msbs_pkg::ALT_B3, msbs_pkg::ALT_B2,
                       msbs_pkg::ALT_B1, msbs_pkg::ALT_B0};
      endcase
      return w[39 - 8 * k -: 8];
   endfunction

   function automatic logic [msbs_pkg::BYTE_W-1:0] noise_byte();
      if ($urandom_range(0, 1) == 1) return msbs_pkg::BYTE_W'($urandom_range(0, 255));
      return sig_byte(sig_pick_type'($urandom_range(0, 2)), $urandom_range(0, 4));
   endfunction

   function automatic logic [msbs_pkg::TRACK_W-1:0] pick_track();
      case ($urandom_range(0, 5))
         0: return ext_setting;
         1: return ext_setting + 7'd1;
         2: return ext_setting - 7'd1;
         3: return '0;
         4: return '1;
         default: return msbs_pkg::TRACK_W'($urandom_range(0, 127));
      endcase
   endfunction

   task automatic send_bytes(input logic [msbs_pkg::BYTE_W-1:0] seq[$],
                             input logic [msbs_pkg::TRACK_W-1:0] trk);
      int gap;
      for (int i = 0; i < seq.size(); i++) begin
         gap = rush ? 0 : pause_cycles(tx_streak);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data_byte <= seq[i];
         req_last_byte <= (i == seq.size() - 1);
         req_track_number <= (i == seq.size() - 1) ? trk
                             : msbs_pkg::TRACK_W'($urandom_range(0, 127));
         do @(posedge clock); while (!req_ready);
         bytes_sent++;
      end
   endtask

   task automatic send_track(input int len, input logic [msbs_pkg::TRACK_W-1:0] trk);
      logic [msbs_pkg::BYTE_W-1:0] body[$];
      sig_pick_type s;
      int n;
      int at;
      repeat (len) body.push_back(noise_byte());
      repeat ($urandom_range(0, 2)) begin
         s = sig_pick_type'($urandom_range(0, 2));
         n = (s == SIG_V2) ? 4 : 5;
         if (n <= len) begin
            at = $urandom_range(0, len - n);
            for (int k = 0; k < n; k++) body[at + k] = sig_byte(s, k);
            // break the planted pattern now and then
            if ($urandom_range(0, 4) == 0) body[at + $urandom_range(0, n - 1)] = noise_byte();
         end
      end
      send_bytes(body, trk);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [msbs_pkg::TRACK_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      ext_setting = v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [msbs_pkg::BYTE_W-1:0] seq[$];
      logic [msbs_pkg::TRACK_W-1:0] v;
      int goal;
      int len;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      seq = {8'hFF};
      send_bytes(seq, 7'd127);
      seq = {8'h00};
      send_bytes(seq, 7'd0);
      seq = {msbs_pkg::V1_B4, msbs_pkg::V1_B3, msbs_pkg::V1_B2, msbs_pkg::V1_B1,
             msbs_pkg::V1_B0};
      send_bytes(seq, 7'd5);
      seq = {msbs_pkg::V2_B3, msbs_pkg::V2_B2, msbs_pkg::V2_B1, msbs_pkg::V2_B0};
      send_bytes(seq, 7'd127);
      seq = {msbs_pkg::ALT_B4, msbs_pkg::ALT_B3, msbs_pkg::ALT_B2, msbs_pkg::ALT_B1,
             msbs_pkg::ALT_B0, 8'h00};
      send_bytes(seq, 7'd36);
      seq = {8'h77, msbs_pkg::V1_B4};
      send_bytes(seq, 7'd36);
      seq = {msbs_pkg::V1_B3, msbs_pkg::V1_B2, msbs_pkg::V1_B1, msbs_pkg::V1_B0};
      send_bytes(seq, 7'd35);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: v = 7'd0;
            1: v = 7'd127;
            3: v = 7'd1;
            4: v = 7'd126;
            default: v = msbs_pkg::TRACK_W'($urandom_range(0, 127));
         endcase
         drain();
         set_threshold(v);
         if (phase == 2) begin
            // hold the verdict side off while short tracks keep coming
            stall_requests++;
            rush = 1'b1;
            repeat (40) send_track($urandom_range(1, 3), pick_track());
            rush = 1'b0;
         end
         goal = bytes_sent + 250;
         while (bytes_sent < goal) begin
            case ($urandom_range(0, 7))
               0: len = $urandom_range(20, 60);
               1: len = $urandom_range(1, 3);
               default: len = $urandom_range(4, 12);
            endcase
            send_track(len, pick_track());
         end
      end
      drain();

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall_requests != stall_served) begin
            stall_served++;
            hold = 400;
         end else begin
            hold = pause_cycles(rx_streak);
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule
